[sv/rpq_pkg.sv]
// Shared types and sizing constants for the radio packet transmit queue.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package rpq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH      = 8;
  localparam int PAYLOAD_BYTES    = 32;
  localparam int ACK_BUFFER_BYTES = 40;

  // Derived widths.
  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int BUILD_W   = 6;
  localparam int TICKS_W   = 16;

  localparam logic [BUILD_W-1:0] BUILD_MAX     = 6'd63;
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd1000;

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_TICK     = 3'd1,
    OP_SUCCESS  = 3'd2,
    OP_FAILURE  = 3'd3,
    OP_FINISHED = 3'd4,
    OP_TX_INFO  = 3'd5,
    OP_ACK      = 3'd6,
    OP_POLL     = 3'd7
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    K_ACCEPTED     = 3'd0,
    K_TOO_LARGE    = 3'd1,
    K_FULL         = 3'd2,
    K_TX_BYTE      = 3'd3,
    K_DONE_OK      = 3'd4,
    K_DONE_FAILED  = 3'd5,
    K_DONE_TIMEOUT = 3'd6
  } kind_t;

  // One input beat.
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last;
    logic       cmd_is_transmit;
    logic [7:0] event_length;
    logic       module_busy;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_data;
    logic [5:0] tx_length;
    logic       is_last;
    logic [5:0] ack_length;
    logic [3:0] queue_count;
  } out_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic eval;
    logic load_send;
    logic send;
    logic tmo_drop;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_send;
    logic send_last;
    logic tmo_pending;
  } dp_status_t;

endpackage

[sv/rpq_ctrl.sv]
// Sequencing state machine for the radio packet transmit queue.
// Depends on rpq_pkg for the command and status structs.
module rpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rpq_pkg::dp_status_t status,
  output rpq_pkg::dp_cmd_t   cmd
);
  import rpq_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_EVAL = 5'b00010,
    C_LOAD = 5'b00100,
    C_SEND = 5'b01000,
    C_TMO  = 5'b10000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt     = C_EVAL;
        end
      end
      C_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.go_send ? C_LOAD : C_IDLE;
      end
      C_LOAD: begin
        cmd.load_send = 1'b1;
        state_nxt     = C_SEND;
      end
      C_SEND: begin
        cmd.send = 1'b1;
        if (status.send_last) begin
          state_nxt = status.tmo_pending ? C_TMO : C_IDLE;
        end
      end
      C_TMO: begin
        cmd.tmo_drop = 1'b1;
        state_nxt    = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != C_IDLE);

endmodule

[sv/rpq_datapath.sv]
// Datapath of the radio packet transmit queue: packet store, length table,
// queue pointers, event flags, handshake state and the result register.
// Depends on rpq_pkg; driven by commands from rpq_ctrl.
module rpq_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpq_pkg::dp_cmd_t           cmd,
  output rpq_pkg::dp_status_t        status,
  input  rpq_pkg::in_item_t          in_item,
  input  logic                       cfg_we,
  input  logic [rpq_pkg::TICKS_W-1:0] cfg_data,
  output logic                       out_valid,
  output rpq_pkg::out_result_t       out_result
);
  import rpq_pkg::*;

  typedef enum logic [3:0] {
    HS_IDLE         = 4'b0001,
    HS_WAIT_SUCCESS = 4'b0010,
    HS_WAIT_FINISH  = 4'b0100,
    HS_WAIT_INFO    = 4'b1000
  } hs_t;

  // Start address of a slot in the packet store.
  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    return ADDR_W'(s * PAYLOAD_BYTES);
  endfunction

  // Control registers.
  in_item_t             item_r;
  hs_t                  hs_r, hs_nxt;
  logic [TICKS_W-1:0]   timeout_left_r, timeout_left_nxt;
  logic [TICKS_W-1:0]   timeout_ticks_r;
  logic [SLOT_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [BUILD_W-1:0]   build_r, build_nxt;
  logic                 flag_succ_r, flag_succ_nxt;
  logic                 flag_fail_r, flag_fail_nxt;
  logic                 flag_fin_r, flag_fin_nxt;
  logic                 flag_info_r, flag_info_nxt;
  logic                 flag_ack_r, flag_ack_nxt;
  logic                 got_info_r, got_info_nxt;
  logic                 got_ack_r, got_ack_nxt;
  logic [7:0]           held_info_r, held_info_nxt;
  logic [7:0]           held_ack_r, held_ack_nxt;
  logic                 cmd_succ_r, cmd_succ_nxt;
  logic                 cmd_fail_r, cmd_fail_nxt;
  logic                 tmo_pending_r, tmo_pending_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [BUILD_W-1:0]   send_idx_r, send_idx_nxt;
  logic [BUILD_W-1:0]   send_len_r, send_len_nxt;
  out_result_t          out_r, out_nxt;
  logic [7:0]           rd_data_r;

  // Stores.
  logic [7:0]           pay_mem [MEM_DEPTH];
  logic [5:0]           len_mem [QUEUE_DEPTH];

  // Store access controls.
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 len_we;
  logic [SLOT_W-1:0]    len_waddr;
  logic [5:0]           len_wdata;
  logic [5:0]           head_len;

  // Queue pointer helpers.
  logic [CNT_W:0]       tail_sum;
  logic [SLOT_W-1:0]    tail;
  logic [SLOT_W-1:0]    head_inc;
  logic                 queue_full;

  // Push helpers.
  logic                 append;
  logic [BUILD_W-1:0]   build_a;

  // Poll evaluation results.
  hs_t                  hs_a;
  logic [TICKS_W-1:0]   tl_a;
  logic                 gi_a, ga_a;
  logic [7:0]           ha_a;
  logic                 drop_a, drop_q, run_idle, go, tmo;
  kind_t                drop_kind_a;
  logic [5:0]           drop_ack_a;
  logic [CNT_W-1:0]     cnt_a;
  hs_t                  hs_b;
  logic [TICKS_W-1:0]   tl_b;
  logic [BUILD_W-1:0]   send_next;

  // Pointer arithmetic shared by push and drop.
  always_comb begin
    tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    tail       = SLOT_W'(tail_sum);
    head_inc   = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    queue_full = (count_r >= CNT_W'(QUEUE_DEPTH));
    head_len   = len_mem[head_r];
    append     = !(item_r.last && (build_r == '0));
    build_a    = (append && (build_r < BUILD_MAX)) ? build_r + 1'b1 : build_r;
    send_next  = send_idx_r + 1'b1;
  end

  // Handshake step taken by a poll, before any transmit start.
  always_comb begin
    hs_a        = hs_r;
    tl_a        = timeout_left_r;
    gi_a        = got_info_r;
    ga_a        = got_ack_r;
    ha_a        = held_ack_r;
    drop_a      = 1'b0;
    drop_kind_a = K_DONE_FAILED;
    drop_ack_a  = '0;
    run_idle    = 1'b0;
    case (hs_r)
      HS_WAIT_SUCCESS: begin
        if (flag_succ_r && cmd_succ_r) begin
          hs_a = HS_WAIT_FINISH;
          tl_a = timeout_ticks_r;
        end else if (flag_fail_r && cmd_fail_r) begin
          drop_a = 1'b1;
          hs_a   = HS_IDLE;
          tl_a   = timeout_ticks_r;
        end
      end
      HS_WAIT_FINISH: begin
        if (flag_fin_r) begin
          hs_a = HS_WAIT_INFO;
          tl_a = timeout_ticks_r;
        end
      end
      HS_WAIT_INFO: begin
        if (flag_info_r) begin
          gi_a = 1'b1;
          if (held_info_r == '0) begin
            ga_a = 1'b1;
            ha_a = '0;
          end
        end
        if (!ga_a && flag_ack_r) begin
          if (ha_a > 8'(ACK_BUFFER_BYTES)) begin
            ha_a = 8'(ACK_BUFFER_BYTES);
          end
          ga_a = 1'b1;
        end
        if (gi_a && ga_a) begin
          drop_a      = 1'b1;
          drop_kind_a = K_DONE_OK;
          drop_ack_a  = ha_a[5:0];
          hs_a        = HS_IDLE;
          tl_a        = timeout_ticks_r;
          run_idle    = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase
    // A drop needs a held packet.
    drop_q = drop_a && (count_r != '0);
    cnt_a  = drop_q ? count_r - 1'b1 : count_r;
    go     = run_idle && (cnt_a != '0) && !item_r.module_busy;
    hs_b   = go ? HS_WAIT_SUCCESS : hs_a;
    tl_b   = go ? timeout_ticks_r : tl_a;
    tmo    = (hs_b != HS_IDLE) && (tl_b == '0);
  end

  // Main next-state logic, one branch per controller command except load_item, which the payload registers take.
  always_comb begin
    hs_nxt           = hs_r;
    timeout_left_nxt = timeout_left_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    build_nxt        = build_r;
    flag_succ_nxt    = flag_succ_r;
    flag_fail_nxt    = flag_fail_r;
    flag_fin_nxt     = flag_fin_r;
    flag_info_nxt    = flag_info_r;
    flag_ack_nxt     = flag_ack_r;
    got_info_nxt     = got_info_r;
    got_ack_nxt      = got_ack_r;
    held_info_nxt    = held_info_r;
    held_ack_nxt     = held_ack_r;
    cmd_succ_nxt     = cmd_succ_r;
    cmd_fail_nxt     = cmd_fail_r;
    tmo_pending_nxt  = tmo_pending_r;
    send_idx_nxt     = send_idx_r;
    send_len_nxt     = send_len_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = '0;
    mem_we           = 1'b0;
    mem_waddr        = slot_base(tail) + ADDR_W'(build_r);
    rd_en            = 1'b0;
    rd_addr          = slot_base(head_r);
    len_we           = 1'b0;
    len_waddr        = tail;
    len_wdata        = build_a;

    if (cmd.eval) begin
      case (item_r.op)
        OP_PUSH: begin
          // Store the byte while it fits and a slot is free.
          if (append && (build_r < BUILD_W'(PAYLOAD_BYTES)) && !queue_full) begin
            mem_we = 1'b1;
          end
          build_nxt = build_a;
          if (item_r.last) begin
            out_valid_nxt     = 1'b1;
            out_nxt.tx_length = build_a;
            out_nxt.is_last   = 1'b1;
            build_nxt         = '0;
            if (build_a > BUILD_W'(PAYLOAD_BYTES)) begin
              out_nxt.kind = K_TOO_LARGE;
            end else if (queue_full) begin
              out_nxt.kind = K_FULL;
            end else begin
              out_nxt.kind = K_ACCEPTED;
              len_we       = 1'b1;
              count_nxt    = count_r + 1'b1;
            end
            out_nxt.queue_count = 4'(count_nxt);
          end
        end
        OP_TICK: begin
          if (timeout_left_r != '0) begin
            timeout_left_nxt = timeout_left_r - 1'b1;
          end
        end
        OP_SUCCESS: begin
          flag_succ_nxt = 1'b1;
          cmd_succ_nxt  = item_r.cmd_is_transmit;
        end
        OP_FAILURE: begin
          flag_fail_nxt = 1'b1;
          cmd_fail_nxt  = item_r.cmd_is_transmit;
        end
        OP_FINISHED: begin
          flag_fin_nxt = 1'b1;
        end
        OP_TX_INFO: begin
          flag_info_nxt = 1'b1;
          held_info_nxt = item_r.event_length;
        end
        OP_ACK: begin
          flag_ack_nxt = 1'b1;
          if (!got_ack_r) begin
            held_ack_nxt = item_r.event_length;
          end
        end
        default: begin
          // Poll: apply the handshake step.
          hs_nxt           = hs_a;
          timeout_left_nxt = tl_a;
          got_info_nxt     = gi_a;
          got_ack_nxt      = ga_a;
          held_ack_nxt     = ha_a;
          if (drop_q) begin
            out_valid_nxt       = 1'b1;
            out_nxt.kind        = drop_kind_a;
            out_nxt.tx_length   = head_len;
            out_nxt.ack_length  = drop_ack_a;
            out_nxt.is_last     = !go;
            out_nxt.queue_count = 4'(cnt_a);
            head_nxt            = head_inc;
            count_nxt           = cnt_a;
          end
          if (go) begin
            // Transmit start clears the latched events.
            flag_succ_nxt    = 1'b0;
            flag_fail_nxt    = 1'b0;
            flag_fin_nxt     = 1'b0;
            flag_info_nxt    = 1'b0;
            flag_ack_nxt     = 1'b0;
            got_info_nxt     = 1'b0;
            got_ack_nxt      = 1'b0;
            hs_nxt           = tmo ? HS_IDLE : HS_WAIT_SUCCESS;
            timeout_left_nxt = timeout_ticks_r;
            tmo_pending_nxt  = tmo;
          end else if (tmo) begin
            hs_nxt           = HS_IDLE;
            timeout_left_nxt = timeout_ticks_r;
            if (count_r != '0) begin
              out_valid_nxt       = 1'b1;
              out_nxt.kind        = K_DONE_TIMEOUT;
              out_nxt.tx_length   = head_len;
              out_nxt.is_last     = 1'b1;
              out_nxt.queue_count = 4'(count_r - 1'b1);
              head_nxt            = head_inc;
              count_nxt           = count_r - 1'b1;
            end
          end
        end
      endcase
    end

    // Fetch the head packet length and its first byte.
    if (cmd.load_send) begin
      send_idx_nxt = '0;
      send_len_nxt = (head_len > 6'(PAYLOAD_BYTES)) ? 6'(PAYLOAD_BYTES) : head_len;
      rd_en        = 1'b1;
    end

    // Stream one byte per cycle; an empty packet sends one marker.
    if (cmd.send) begin
      out_valid_nxt       = 1'b1;
      out_nxt.kind        = K_TX_BYTE;
      out_nxt.tx_data     = (send_len_r == '0) ? 8'd0 : rd_data_r;
      out_nxt.tx_length   = send_len_r;
      out_nxt.is_last     = status.send_last && !tmo_pending_r;
      out_nxt.queue_count = 4'(count_r);
      send_idx_nxt        = send_next;
      rd_en               = (send_next < send_len_r);
      rd_addr             = slot_base(head_r) + ADDR_W'(send_next);
    end

    // Timeout right after a transmit start drops the packet just sent.
    if (cmd.tmo_drop) begin
      tmo_pending_nxt = 1'b0;
      if (count_r != '0) begin
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = K_DONE_TIMEOUT;
        out_nxt.tx_length   = head_len;
        out_nxt.is_last     = 1'b1;
        out_nxt.queue_count = 4'(count_r - 1'b1);
        head_nxt            = head_inc;
        count_nxt           = count_r - 1'b1;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    status.go_send     = (item_r.op == OP_POLL) && go;
    status.send_last   = (send_len_r == '0) || (send_next == send_len_r);
    status.tmo_pending = tmo_pending_r;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r            <= HS_IDLE;
      timeout_left_r  <= '0;
      timeout_ticks_r <= TIMEOUT_RESET;
      head_r          <= '0;
      count_r         <= '0;
      build_r         <= '0;
      flag_succ_r     <= 1'b0;
      flag_fail_r     <= 1'b0;
      flag_fin_r      <= 1'b0;
      flag_info_r     <= 1'b0;
      flag_ack_r      <= 1'b0;
      got_info_r      <= 1'b0;
      got_ack_r       <= 1'b0;
      held_info_r     <= '0;
      held_ack_r      <= '0;
      cmd_succ_r      <= 1'b0;
      cmd_fail_r      <= 1'b0;
      tmo_pending_r   <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      hs_r            <= hs_nxt;
      timeout_left_r  <= timeout_left_nxt;
      head_r          <= head_nxt;
      count_r         <= count_nxt;
      build_r         <= build_nxt;
      flag_succ_r     <= flag_succ_nxt;
      flag_fail_r     <= flag_fail_nxt;
      flag_fin_r      <= flag_fin_nxt;
      flag_info_r     <= flag_info_nxt;
      flag_ack_r      <= flag_ack_nxt;
      got_info_r      <= got_info_nxt;
      got_ack_r       <= got_ack_nxt;
      held_info_r     <= held_info_nxt;
      held_ack_r      <= held_ack_nxt;
      cmd_succ_r      <= cmd_succ_nxt;
      cmd_fail_r      <= cmd_fail_nxt;
      tmo_pending_r   <= tmo_pending_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we) begin
        timeout_ticks_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    send_idx_r <= send_idx_nxt;
    send_len_r <= send_len_nxt;
    out_r      <= out_nxt;
  end

  // Packet store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[mem_waddr] <= item_r.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= pay_mem[rd_addr];
    end
  end

  // Packet length table, written at the tail slot.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

[sv/radio_packet_transmit_queue.sv]
// Top level of the radio packet transmit queue.
// Depends on rpq_pkg, rpq_ctrl and rpq_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   input    | start / busy         | in_item (in_item_t)
//   result   | out_valid strobe     | out_result (out_result_t)
//   config   | cfg_valid / cfg_ready| cfg_data (timeout_ticks)
//
// Push, tick and event items are evaluated in the busy state, then the idle
// cycle after it shows the result, if any.
// A poll that starts a transmit adds a length fetch, then one payload byte per
// cycle (one marker for an empty packet), set by the single read port of the
// packet store, and a timeout drop if the timeout is due at the start.
// Each result is shown for one cycle; the receiver cannot stall.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
module radio_packet_transmit_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  rpq_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output rpq_pkg::out_result_t        out_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpq_pkg::TICKS_W-1:0] cfg_data
);
  import rpq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // Configuration is taken whenever the block is idle.
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  rpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  rpq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

[sv/rpq_checker.sv]
// Port-level checker for the radio packet transmit queue, bound to the top.
// Depends on rpq_pkg and radio_packet_transmit_queue.
module rpq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input rpq_pkg::out_result_t out_result
);
  import rpq_pkg::*;

  // An accepted item always keeps the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Results only come out of work that was under way in the cycle before.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // The final result of an item is followed by a quiet cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.is_last) |=> !out_valid)
    else $error("result beat right after a final beat");

  // Transmit bytes stream without gaps until the item's final result.
  a_byte_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.kind == K_TX_BYTE) && !out_result.is_last) |=> out_valid)
    else $error("gap inside a transmit byte stream");

  // The reported queue occupancy never exceeds the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.queue_count <= 4'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

endmodule

bind radio_packet_transmit_queue rpq_checker u_rpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
